@@ sv/gcd_pkg.sv @@
package gcd_pkg;

    localparam int MaxItemsDef = 1024;
    localparam int LevelsDef   = 11;
    localparam int ValueW      = 31;
    localparam int CountW      = 20;

    typedef enum logic [1:0] {
        G_IDLE,
        G_RUN,
        G_DONE
    } t_gcd_state;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BUILD_RD,
        S_BUILD_RD2,
        S_BUILD_GCD,
        S_BUILD_WR,
        S_Q_INIT,
        S_Q_LEVEL,
        S_Q_RD,
        S_Q_GCD,
        S_Q_NEXT,
        S_Q_ADD,
        S_OUT
    } t_seq_state;

    // Handshake between the sequencer and the shared GCD unit.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_gcd_ctl;

endpackage

@@ sv/gcd_euclid.sv @@
module gcd_euclid (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [gcd_pkg::ValueW-1:0] i_a,
    input  logic [gcd_pkg::ValueW-1:0] i_b,
    output gcd_pkg::t_gcd_ctl      o_ctl,
    output logic [gcd_pkg::ValueW-1:0] o_gcd
);
    import gcd_pkg::*;

    t_gcd_state r_state, n_state;
    logic [ValueW-1:0] r_a, r_b, n_a, n_b;
    logic [4:0]        r_sh, n_sh;

    // Binary GCD: one halving, or one subtract and halving, per cycle.
    // Common factors of two are counted in r_sh and restored at the end.
    always_comb begin
        n_state = r_state;
        n_a = r_a;
        n_b = r_b;
        n_sh = r_sh;
        unique case (r_state)
            G_IDLE: begin
                if (i_start) begin
                    n_a = i_a;
                    n_b = i_b;
                    n_sh = '0;
                    n_state = G_RUN;
                end
            end
            G_RUN: begin
                if (r_a == '0 || r_b == '0) begin
                    n_a = (r_a | r_b) << r_sh;
                    n_state = G_DONE;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_sh = r_sh + 1'b1;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (r_a >= r_b) begin
                    n_a = (r_a - r_b) >> 1;
                end else begin
                    n_b = (r_b - r_a) >> 1;
                end
            end
            G_DONE:  n_state = G_IDLE;
            default: n_state = G_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a  <= n_a;
        r_b  <= n_b;
        r_sh <= n_sh;
    end

    always_comb begin
        o_ctl.start = (r_state == G_IDLE) && i_start;
        o_ctl.busy  = (r_state != G_IDLE);
        o_ctl.done  = (r_state == G_DONE);
    end
    assign o_gcd = r_a;

endmodule

@@ sv/gcd_one_subarray_counter_unit.sv @@
// GCD-one subarray counter.
// Input channel (s_axis): one beat per array element, value in tdata,
// tlast marking the final element of a data set. Elements beyond MAX_ITEMS
// are dropped. While elements arrive, one beat is taken per cycle.
// After the last beat the block stops accepting beats, builds the sparse
// table of range GCDs in its memory and runs the greedy query for every
// left end, all through one shared binary GCD unit, which does one halving
// or subtract per cycle on 31-bit operands. A data set of n elements takes
// roughly 2*n*log2(n) GCD operations; this unit sets the throughput.
// Output channel (m_axis): one beat carrying the 20-bit count per data set.
// The result is held in an output register until the receiver takes it;
// meanwhile the next data set may already be loaded and processed, and only
// the hand-over of its own result waits for the register to empty.
// Reset clears the sequencer, the element count and the total; the table
// memory needs no clearing since only entries written for the current
// data set are read.
module gcd_one_subarray_counter_unit #(
    parameter int MAX_ITEMS = gcd_pkg::MaxItemsDef,
    parameter int LEVELS    = gcd_pkg::LevelsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] value, [31] zero fill
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [19:0] subarray_count, [23:20] zero fill
);
    import gcd_pkg::*;

    localparam int IW    = $clog2(MAX_ITEMS);
    localparam int NW    = $clog2(MAX_ITEMS + 1);
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DEPTH = LEVELS * MAX_ITEMS;
    localparam int AW    = $clog2(DEPTH);

    t_seq_state r_state, n_state;
    logic [NW-1:0] r_n, n_n;          // element count
    logic [LW-1:0] r_top, n_top;      // top level used
    logic [LW-1:0] r_k, n_k;          // current level
    logic [NW:0]   r_j, n_j;          // current index or left end
    logic [NW:0]   r_r, n_r;          // greedy position
    logic [ValueW-1:0] r_g, n_g;      // running GCD
    logic [ValueW-1:0] r_op, n_op;    // first GCD operand
    logic [CountW-1:0] r_total, n_total;
    logic [CountW-1:0] r_out;
    logic              r_ovalid;

    // Table memory.
    logic [ValueW-1:0] r_mem [DEPTH];
    logic [ValueW-1:0] r_rdata;
    logic [AW-1:0]     w_raddr, w_waddr;
    logic [ValueW-1:0] w_wdata;
    logic              w_we;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    // Shared GCD unit.
    t_gcd_ctl          w_ctl;
    logic              w_gstart;
    logic [ValueW-1:0] w_ga, w_gb, w_gres;

    gcd_euclid u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gstart),
        .i_a     (w_ga),
        .i_b     (w_gb),
        .o_ctl   (w_ctl),
        .o_gcd   (w_gres)
    );

    function automatic logic [AW-1:0] addr_of(logic [LW-1:0] lv, logic [NW:0] idx);
        logic [AW+NW:0] t;
        t = AW'(lv) * AW'(MAX_ITEMS) + (AW+NW+1)'(idx);
        return t[AW-1:0];
    endfunction

    logic w_acc;
    logic [NW+1:0] w_span_end, w_q_end;
    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_span_end = (NW+2)'(r_j) + ((NW+2)'(1) << r_k);
    assign w_q_end    = (NW+2)'(r_r) + ((NW+2)'(1) << r_k);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_n = r_n; n_top = r_top; n_k = r_k; n_j = r_j; n_r = r_r;
        n_g = r_g; n_op = r_op; n_total = r_total;
        unique case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    if (r_n < NW'(MAX_ITEMS)) n_n = r_n + 1'b1;
                    if (s_axis_tlast) begin
                        n_top = '0;
                        for (int b = 1; b < NW; b++) begin
                            if (n_n >= NW'(1 << b) && b <= LEVELS - 1) n_top = LW'(b);
                        end
                        n_k = LW'(1);
                        n_j = '0;
                        n_state = (n_top == '0) ? S_Q_INIT : S_BUILD_RD;
                    end
                end
            end
            S_BUILD_RD: begin
                if (w_span_end > (NW+2)'(r_n)) begin
                    n_j = '0;
                    if (r_k == r_top) begin
                        n_state = S_Q_INIT;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end else begin
                    n_state = S_BUILD_RD2;
                end
            end
            S_BUILD_RD2: begin
                n_op = r_rdata;
                n_state = S_BUILD_GCD;
            end
            S_BUILD_GCD: begin
                if (w_ctl.done) n_state = S_BUILD_WR;
            end
            S_BUILD_WR: begin
                n_j = r_j + 1'b1;
                n_state = S_BUILD_RD;
            end
            S_Q_INIT: begin
                n_total = '0;
                n_j = '0;
                n_r = '0;
                n_g = '0;
                n_k = r_top;
                n_state = S_Q_LEVEL;
            end
            S_Q_LEVEL: begin
                if (w_q_end > (NW+2)'(r_n)) n_state = S_Q_NEXT;
                else n_state = S_Q_RD;
            end
            S_Q_RD:  n_state = S_Q_GCD;
            S_Q_GCD: begin
                if (w_ctl.done) begin
                    if (w_gres > ValueW'(1)) begin
                        n_g = w_gres;
                        n_r = r_r + ((NW+1)'(1) << r_k);
                    end
                    n_state = S_Q_NEXT;
                end
            end
            S_Q_NEXT: begin
                if (r_k == '0) begin
                    n_state = S_Q_ADD;
                end else begin
                    n_k = r_k - 1'b1;
                    n_state = S_Q_LEVEL;
                end
            end
            S_Q_ADD: begin
                n_total = r_total + CountW'((NW+1)'(r_n) - r_r);
                n_j = r_j + 1'b1;
                n_r = r_j + 1'b1;
                n_g = '0;
                n_k = r_top;
                n_state = ((r_j + 1'b1) == (NW+1)'(r_n)) ? S_OUT : S_Q_LEVEL;
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_n = '0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Output and datapath control.
    always_comb begin
        s_axis_tready = (r_state == S_LOAD);
        w_we    = 1'b0;
        w_waddr = addr_of(r_k, r_j);
        w_wdata = w_gres;
        w_raddr = addr_of(r_k - 1'b1, r_j);
        w_gstart = 1'b0;
        w_ga = r_op;
        w_gb = r_rdata;
        unique case (r_state)
            S_LOAD: begin
                w_we    = w_acc && (r_n < NW'(MAX_ITEMS));
                w_waddr = addr_of('0, (NW+1)'(r_n));
                w_wdata = s_axis_tdata[ValueW-1:0];
            end
            S_BUILD_RD:  w_raddr = addr_of(r_k - 1'b1, r_j);
            S_BUILD_RD2: w_raddr = addr_of(r_k - 1'b1,
                                           r_j + ((NW+1)'(1) << (r_k - 1'b1)));
            S_BUILD_GCD: w_gstart = !w_ctl.busy;
            S_BUILD_WR:  w_we = 1'b1;
            S_Q_LEVEL:   w_raddr = addr_of(r_k, r_r);
            S_Q_RD:      w_raddr = addr_of(r_k, r_r);
            S_Q_GCD: begin
                w_ga = r_g;
                w_gstart = !w_ctl.busy;
            end
            default: ;
        endcase
    end

    // The GCD unit latches both operands on its start cycle, so the read
    // address may move on once the unit has started.

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_n      <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_total <= n_total;
            if (r_state == S_OUT && !r_ovalid) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
        end
        r_top <= n_top;
        r_k   <= n_k;
        r_j   <= n_j;
        r_r   <= n_r;
        r_g   <= n_g;
        r_op  <= n_op;
        if (r_state == S_OUT && !r_ovalid) r_out <= r_total;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0, r_out};

endmodule
